// ===== rtl/fdc_pkg.sv =====
`timescale 1ns / 1ps
package fdc_pkg;

  localparam int unsigned MOTOR_W = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = MOTOR_W;

  localparam logic [MOTOR_W-1:0] MOTOR_MAX = {MOTOR_W{1'b1}};
  localparam logic [BYTE_W-1:0]  BYTE_MAX  = {BYTE_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 2'd2;

  localparam logic [MOTOR_W-1:0] RST_MOTOR_DELAY = 21'd1020484;
  localparam logic [BYTE_W-1:0]  RST_BIT_PERIOD  = 8'd4;
  localparam logic [BYTE_W-1:0]  RST_HOLD_TIME   = 8'd8;

  // item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // soft switches above the stepper phases
  localparam logic [3:0] SW_MOTOR_OFF = 4'h8;
  localparam logic [3:0] SW_MOTOR_ON  = 4'h9;
  localparam logic [3:0] SW_DRIVE_1   = 4'hA;
  localparam logic [3:0] SW_DRIVE_2   = 4'hB;
  localparam logic [3:0] SW_Q6_LOW    = 4'hC;
  localparam logic [3:0] SW_Q6_HIGH   = 4'hD;
  localparam logic [3:0] SW_Q7_LOW    = 4'hE;
  localparam logic [3:0] SW_Q7_HIGH   = 4'hF;
  localparam logic [3:0] SW_PHASE_LAST = 4'h7;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_OFF  = 2'd1;
  localparam logic [1:0] PHASE_ON   = 2'd2;

  localparam logic [1:0] SPIN_NONE  = 2'd0;
  localparam logic [1:0] SPIN_START = 2'd1;
  localparam logic [1:0] SPIN_STOP  = 2'd2;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor_delay;
    logic [BYTE_W-1:0]  bit_period;
    logic [BYTE_W-1:0]  hold_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] address;
    logic       disk_bit;
    logic       write_protect;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              motor_line;
    logic              active_drive;
    logic [1:0]        phase_op;
    logic [1:0]        phase_number;
    logic [1:0]        spin_cmd;
    logic              bit_taken;
  } result_t;

endpackage

// ===== rtl/fdc_ifs.sv =====
`timescale 1ns / 1ps
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] address;
  logic       disk_bit;
  logic       write_protect;
  modport source(output valid, kind, address, disk_bit, write_protect, input ready);
  modport sink(input valid, kind, address, disk_bit, write_protect, output ready);
endinterface

interface fdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       motor_line;
  logic       active_drive;
  logic [1:0] phase_op;
  logic [1:0] phase_number;
  logic [1:0] spin_cmd;
  logic       bit_taken;
  modport source(output valid, read_data, motor_line, active_drive, phase_op,
                 phase_number, spin_cmd, bit_taken, input ready);
  modport sink(input valid, read_data, motor_line, active_drive, phase_op,
               phase_number, spin_cmd, bit_taken, output ready);
endinterface

interface fdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/fdc_cfg_regs.sv =====
`timescale 1ns / 1ps
module fdc_cfg_regs
  import fdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_delay <= RST_MOTOR_DELAY;
      cfg_r.bit_period  <= RST_BIT_PERIOD;
      cfg_r.hold_time   <= RST_HOLD_TIME;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MOTOR_DELAY: cfg_r.motor_delay <= wr_data[MOTOR_W-1:0];
        CFG_BIT_PERIOD:  cfg_r.bit_period  <= wr_data[BYTE_W-1:0];
        CFG_HOLD_TIME:   cfg_r.hold_time   <= wr_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/fdc_core.sv =====
`timescale 1ns / 1ps
module fdc_core
  import fdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t res
);

  logic q6_r, q6_nxt, q7_r, q7_nxt, prot_r, prot_nxt;
  logic [BYTE_W-1:0] latch_r, latch_nxt, asm_r, asm_nxt;
  logic [BYTE_W-1:0] bit_tmr_r, bit_tmr_nxt, hold_r, hold_nxt;
  logic [MOTOR_W-1:0] mtr_tmr_r, mtr_tmr_nxt;
  logic starting_r, starting_nxt, stopping_r, stopping_nxt, running_r, running_nxt;
  logic cur_drv_r, cur_drv_nxt, pend_drv_r, pend_drv_nxt;

  logic [BYTE_W-1:0] shifted;
  logic              is_read;

  always_comb begin
    q6_nxt       = q6_r;
    q7_nxt       = q7_r;
    prot_nxt     = prot_r;
    latch_nxt    = latch_r;
    asm_nxt      = asm_r;
    bit_tmr_nxt  = bit_tmr_r;
    hold_nxt     = hold_r;
    mtr_tmr_nxt  = mtr_tmr_r;
    starting_nxt = starting_r;
    stopping_nxt = stopping_r;
    running_nxt  = running_r;
    cur_drv_nxt  = cur_drv_r;
    pend_drv_nxt = pend_drv_r;
    res          = '0;
    shifted      = {asm_r[BYTE_W-2:0], item.disk_bit};
    is_read      = (item.kind == KIND_READ);

    if (item.kind == KIND_TICK) begin
      if (hold_r != BYTE_MAX) hold_nxt = hold_r + 8'd1;
      if (starting_r || stopping_r) begin
        if (mtr_tmr_r != MOTOR_MAX) mtr_tmr_nxt = mtr_tmr_r + 21'd1;
        // a zero delay behaves as one: the incremented count is never zero
        if (mtr_tmr_nxt >= cfg.motor_delay) begin
          if (starting_r) begin
            starting_nxt = 1'b0;
            running_nxt  = 1'b1;
          end else begin
            stopping_nxt = 1'b0;
            running_nxt  = 1'b0;
            bit_tmr_nxt  = '0;
            res.spin_cmd = SPIN_STOP;
          end
        end
        cur_drv_nxt = pend_drv_r;
      end
      if (running_nxt) begin
        bit_tmr_nxt = bit_tmr_nxt + 8'd1;
        if (bit_tmr_nxt >= cfg.bit_period) begin
          bit_tmr_nxt   = '0;
          res.bit_taken = 1'b1;
          if (shifted[BYTE_W-1]) begin
            latch_nxt = shifted;
            asm_nxt   = '0;
            hold_nxt  = '0;
          end else begin
            asm_nxt = shifted;
            if (hold_nxt >= cfg.hold_time) latch_nxt = '0;
          end
        end
      end
    end else if (item.kind == KIND_READ || item.kind == KIND_WRITE) begin
      res.read_data = {4'd0, item.address};
      if (item.address inside {[4'h0:SW_PHASE_LAST]}) begin
        res.phase_op     = item.address[0] ? PHASE_ON : PHASE_OFF;
        res.phase_number = item.address[2:1];
      end else begin
        case (item.address)
          SW_MOTOR_OFF: begin
            starting_nxt = 1'b0;
            stopping_nxt = 1'b1;
            mtr_tmr_nxt  = '0;
          end
          SW_MOTOR_ON: begin
            stopping_nxt = 1'b0;
            starting_nxt = 1'b1;
            mtr_tmr_nxt  = '0;
            res.spin_cmd = SPIN_START;
          end
          SW_DRIVE_1, SW_DRIVE_2: begin
            pend_drv_nxt = item.address[0];
            // switching drives while spinning also starts a motor stop
            if (running_r && (cur_drv_r != item.address[0])) begin
              starting_nxt = 1'b0;
              stopping_nxt = 1'b1;
              mtr_tmr_nxt  = '0;
            end
          end
          SW_Q6_LOW: begin
            q6_nxt = 1'b0;
            if (is_read && !q7_r) begin
              res.read_data = latch_r;
              if (latch_r[BYTE_W-1]) latch_nxt = '0;
            end
          end
          SW_Q6_HIGH: begin
            q6_nxt   = 1'b1;
            prot_nxt = item.write_protect;
            if (is_read) latch_nxt = '0;
          end
          SW_Q7_LOW: begin
            q7_nxt = 1'b0;
            if (q6_r) prot_nxt = item.write_protect;
            if (is_read && q6_r) res.read_data = {prot_nxt, 7'd0};
          end
          default: begin
            q7_nxt = 1'b1;
            if (q6_r) prot_nxt = item.write_protect;
          end
        endcase
      end
      if (!is_read) res.read_data = '0;
    end

    res.motor_line   = running_nxt;
    res.active_drive = cur_drv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q6_r       <= 1'b0;
      q7_r       <= 1'b0;
      prot_r     <= 1'b0;
      latch_r    <= '0;
      asm_r      <= '0;
      bit_tmr_r  <= '0;
      hold_r     <= '0;
      mtr_tmr_r  <= '0;
      starting_r <= 1'b0;
      stopping_r <= 1'b0;
      running_r  <= 1'b0;
      cur_drv_r  <= 1'b0;
      pend_drv_r <= 1'b0;
    end else if (fire) begin
      q6_r       <= q6_nxt;
      q7_r       <= q7_nxt;
      prot_r     <= prot_nxt;
      latch_r    <= latch_nxt;
      asm_r      <= asm_nxt;
      bit_tmr_r  <= bit_tmr_nxt;
      hold_r     <= hold_nxt;
      mtr_tmr_r  <= mtr_tmr_nxt;
      starting_r <= starting_nxt;
      stopping_r <= stopping_nxt;
      running_r  <= running_nxt;
      cur_drv_r  <= cur_drv_nxt;
      pend_drv_r <= pend_drv_nxt;
    end
  end

endmodule

// ===== rtl/floppy_controller_read_path.sv =====
`timescale 1ns / 1ps
// Path: input register, single compute stage holding all state updates, result register.
// Throughput: one item per cycle while the output takes results.
// The input register takes a new item while a result waits on the output side.
// Reset (rst_n low, synchronous): pipeline empty, all controller state cleared,
// registers back to motor_delay 1020484, bit_period 4, hold_time 8.
module floppy_controller_read_path
  import fdc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  fdc_in_if.sink       in_if,
  fdc_out_if.source    out_if,
  fdc_cfg_if.sink      cfg_if
);

  cfg_t    cfg;
  item_t   item_r;
  result_t res, res_r;
  logic    in_vld_r, out_vld_r, fire;

  assign fire        = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || fire;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.kind          <= in_if.kind;
      item_r.address       <= in_if.address;
      item_r.disk_bit      <= in_if.disk_bit;
      item_r.write_protect <= in_if.write_protect;
    end
  end

  fdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid && cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  fdc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res;
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.read_data    = res_r.read_data;
  assign out_if.motor_line   = res_r.motor_line;
  assign out_if.active_drive = res_r.active_drive;
  assign out_if.phase_op     = res_r.phase_op;
  assign out_if.phase_number = res_r.phase_number;
  assign out_if.spin_cmd     = res_r.spin_cmd;
  assign out_if.bit_taken    = res_r.bit_taken;

`ifndef NO_ASSERTIONS
  // a bit is only shifted in while the motor runs
  a_taken_needs_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.bit_taken |-> res_r.motor_line)
    else $error("bit taken with motor stopped");

  // a completed stop leaves the motor off and takes no bit in the same tick
  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.spin_cmd == SPIN_STOP |-> !res_r.motor_line && !res_r.bit_taken)
    else $error("stop reported with motor running or bit taken");

  // stepper commands never coincide with spin commands or bit shifts
  a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.phase_op != PHASE_NONE |->
      res_r.spin_cmd == SPIN_NONE && !res_r.bit_taken)
    else $error("phase command mixed with other activity");

  // no result appears without an item in the compute stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(in_vld_r))
    else $error("result without an item");
`endif

endmodule
